// ----- rtl/bsa_pkg.sv -----
package bsa_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_IDX_W = 6;
   localparam int SLOT_W    = 12;

   typedef struct packed {
      logic              want_any;
      logic [SLOT_W-1:0] preferred_index;
   } bsa_req_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot_index;
   } bsa_rsp_type;

endpackage

// ----- rtl/bsa_find_first.sv -----
module bsa_find_first
   import bsa_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   output logic                 found,
   output logic [BIT_IDX_W-1:0] pos
);

   always_comb begin
      found = |word;
      pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = BIT_IDX_W'(i);
         end
      end
   end

endmodule

// ----- rtl/bitmap_slot_allocator.sv -----
// Channel   Direction  Ports                         Item
// request   in         req_valid req_ready req_data  want_any, preferred_index
// response  out        rsp_valid rsp_ready rsp_data  granted, slot_index
//
// A named slot: the accepting edge registers the group word, and ST_CHECK then
// checks the bit and writes back. A request refused at once reads no word and
// answers from ST_FAIL. A search first scans in ST_SCAN; k (1 to GROUP_COUNT/64
// rounded up) is the number of summary chunks that the shared find-first unit
// scans before the bit. After reset the group memory is filled with ones, with
// no request taken; a response that is not taken holds the block before write-back.
module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int SLOT_TOTAL  = 4096,
   parameter int GROUP_COUNT = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bsa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bsa_rsp_type rsp_data
);

   localparam int GW     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int HW     = $clog2(GROUP_COUNT + 1);
   localparam int CHUNKS = (GROUP_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int SUMW   = CHUNKS * WORD_BITS;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FAIL
   } state_type;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bsa_rsp_type           rsp_ff, rsp_in;
   logic [HW-1:0]         hint_ff, hint_in;
   logic [SUMW-1:0]       sum_ff, sum_in;
   logic [GW-1:0]         clr_ff, clr_in;
   logic [CW-1:0]         chunk_ff, chunk_in;
   logic                  first_ff, first_in;
   logic [GW-1:0]         grp_ff, grp_in;
   logic [BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic                  any_ff, any_in;
   logic [WORD_BITS-1:0]  rdata_ff;

   logic [WORD_BITS-1:0]  map_mem [GROUP_COUNT];
   logic                  mem_we;
   logic [GW-1:0]         mem_waddr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic                  mem_re;
   logic [GW-1:0]         mem_raddr;

   logic [WORD_BITS-1:0]  ff_word;
   logic                  ff_found;
   logic [BIT_IDX_W-1:0]  ff_pos;
   logic [WORD_BITS-1:0]  scan_word;
   logic [GW-1:0]         scan_grp;
   logic [GW-1:0]         pref_grp;
   logic                  pref_bad;
   logic [BIT_IDX_W-1:0]  chk_bit;
   logic [GW+BIT_IDX_W-1:0] chk_slot;
   logic                  chk_ok;
   logic [WORD_BITS-1:0]  new_word;
   logic                  out_free;

   bsa_find_first u_find_first (
      .word  (ff_word),
      .found (ff_found),
      .pos   (ff_pos)
   );

   assign scan_word = sum_ff[chunk_ff*WORD_BITS +: WORD_BITS]
                      & (first_ff ? ({WORD_BITS{1'b1}} << BIT_IDX_W'(hint_ff))
                                  : {WORD_BITS{1'b1}});
   assign scan_grp  = GW'({chunk_ff, ff_pos});
   assign ff_word   = (state_ff == ST_CHECK) ? rdata_ff : scan_word;

   assign pref_grp  = GW'(req_data.preferred_index[SLOT_W-1:BIT_IDX_W]);
   assign pref_bad  = (32'(req_data.preferred_index) >= 32'(SLOT_TOTAL))
                      || (32'(req_data.preferred_index[SLOT_W-1:BIT_IDX_W])
                          >= 32'(GROUP_COUNT));

   assign chk_bit   = any_ff ? ff_pos : bit_ff;
   assign chk_slot  = {grp_ff, chk_bit};
   assign chk_ok    = rdata_ff[chk_bit] && (32'(chk_slot) < 32'(SLOT_TOTAL));
   assign new_word  = rdata_ff & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << chk_bit);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      hint_in      = hint_ff;
      sum_in       = sum_ff;
      clr_in       = clr_ff;
      chunk_in     = chunk_ff;
      first_in     = first_ff;
      grp_in       = grp_ff;
      bit_in       = bit_ff;
      any_in       = any_ff;
      mem_we       = 1'b0;
      mem_waddr    = grp_ff;
      mem_wdata    = new_word;
      mem_re       = 1'b0;
      mem_raddr    = pref_grp;
      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = {WORD_BITS{1'b1}};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == GW'(GROUP_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               any_in = req_data.want_any;
               bit_in = req_data.preferred_index[BIT_IDX_W-1:0];
               grp_in = pref_grp;
               if (req_data.want_any) begin
                  if (32'(hint_ff) >= 32'(GROUP_COUNT)) begin
                     state_in = ST_FAIL;
                  end else begin
                     chunk_in = CW'(hint_ff >> BIT_IDX_W);
                     first_in = 1'b1;
                     state_in = ST_SCAN;
                  end
               end else if (pref_bad) begin
                  state_in = ST_FAIL;
               end else begin
                  mem_re   = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SCAN: begin
            if (ff_found) begin
               grp_in    = scan_grp;
               mem_re    = 1'b1;
               mem_raddr = scan_grp;
               state_in  = ST_CHECK;
            end else if (chunk_ff == CW'(CHUNKS - 1)) begin
               state_in = ST_FAIL;
            end else begin
               chunk_in = chunk_ff + 1'b1;
               first_in = 1'b0;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.granted     = chk_ok;
               rsp_in.slot_index  = chk_ok ? SLOT_W'(chk_slot) : '0;
               if (chk_ok) begin
                  mem_we         = 1'b1;
                  sum_in[grp_ff] = |new_word;
                  if ((HW'(grp_ff) == hint_ff) && (new_word == '0)) begin
                     hint_in = HW'(32'(grp_ff) + 1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.granted    = 1'b0;
               rsp_in.slot_index = '0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         hint_ff      <= '0;
         clr_ff       <= '0;
         for (int i = 0; i < SUMW; i++) begin
            sum_ff[i] <= (i < GROUP_COUNT);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hint_ff      <= hint_in;
         clr_ff       <= clr_in;
         sum_ff       <= sum_in;
      end
      rsp_ff   <= rsp_in;
      chunk_ff <= chunk_in;
      first_ff <= first_in;
      grp_ff   <= grp_in;
      bit_ff   <= bit_in;
      any_ff   <= any_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= map_mem[mem_raddr];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   hint_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(hint_ff) <= 32'(GROUP_COUNT))
      else $error("start group hint beyond the last group");

   search_hits_free_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && any_ff |-> ff_found && rdata_ff[ff_pos])
      else $error("summary marked a group non-empty but its word has no free bit");

   fail_has_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.granted |-> rsp_ff.slot_index == '0)
      else $error("failed item carries a slot number");

   grant_clears_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && out_free && chk_ok
      |=> !$past(new_word[chk_bit]) && rsp_valid_ff && rsp_ff.granted)
      else $error("granted slot not taken from the map");

endmodule
